// ----- hw/rtl/bounded_deque_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, cond, expct, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expct)) else $error(msg);

`endif

// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

  // Widest stored value and width of the reported length.
  localparam int MAX_VALUE_BITS = 64;
  localparam int LEN_BITS       = 7;

  typedef enum logic [2:0] {
    KIND_APPEND_REAR  = 3'd0,
    KIND_INSERT_FRONT = 3'd1,
    KIND_REMOVE_FRONT = 3'd2,
    KIND_REMOVE_REAR  = 3'd3,
    KIND_LENGTH       = 3'd4,
    KIND_DUMP         = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE_AT,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t                  op;
    logic [LEN_BITS-1:0]       count;
    logic [MAX_VALUE_BITS-1:0] value;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/bounded_deque.sv -----
// Bounded double-ended queue of signed values held in a chain of cells,
// front entry in cell 0.
// Input channel s_*: one request per item, kind in s_tuser, value in
// s_tdata. Output channel m_*: result items with data and length in
// m_tdata, status in m_tuser and m_tlast on the final result of a request.
// Append, insert, remove, length and unused kinds give one result, which is
// registered in the output register when the request is taken; a new request
// is taken in the cycle that register is freed, so these sustain one
// request per cycle while the receiver keeps m_tready high.
// Dump gives one result per held entry (one empty-status result if none),
// one per cycle while m_tready is high, via ST_DUMP and the output register;
// the chain rotates one place per result and new requests are blocked.
// Reset empties the deque (length zero); cell contents are not cleared.
// When the receiver stalls, the pending result holds, the chain holds and
// no new request is taken until the result is taken.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data, [38:32] length, [39] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  `include "bounded_deque_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  dump_idx, dump_idx_next;
  logic [31:0]       out_data, out_data_next;
  logic [LEN_BITS-1:0] out_len, out_len_next;
  status_t           out_status, out_status_next;
  logic              out_last, out_last_next;
  logic              out_load;
  logic              out_free;
  logic              accept;
  logic              dump_last;
  kind_t             kind;
  cell_ctl_t         ctl;

  logic [VALUE_BITS-1:0] cell_q [DEPTH];
  logic signed [63:0]    front_ext;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign kind     = kind_t'(s_tuser);

  assign front_ext = 64'(signed'(cell_q[0]));
  assign dump_last = (CNT_W'(dump_idx) == count - CNT_W'(1));

  always_comb begin
    state_next      = state;
    count_next      = count;
    dump_idx_next   = dump_idx;
    out_load        = 1'b0;
    out_data_next   = '0;
    out_status_next = STATUS_OK;
    out_last_next   = 1'b1;
    ctl.op          = CELL_HOLD;
    ctl.count       = LEN_BITS'(count);
    ctl.value       = MAX_VALUE_BITS'($unsigned(s_tdata[31:0]));
    case (state)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (kind)
            KIND_APPEND_REAR, KIND_INSERT_FRONT: begin
              if (count == FULL_COUNT) begin
                out_status_next = STATUS_FULL;
              end else begin
                ctl.op     = (kind == KIND_APPEND_REAR) ? CELL_WRITE_AT : CELL_SHIFT_IN;
                count_next = count + CNT_W'(1);
              end
            end
            KIND_REMOVE_FRONT, KIND_REMOVE_REAR: begin
              if (count == '0) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                if (kind == KIND_REMOVE_FRONT) begin
                  ctl.op = CELL_SHIFT_OUT;
                end
                count_next = count - CNT_W'(1);
              end
            end
            KIND_DUMP: begin
              if (count == '0) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                // results come from the dump walk instead
                out_load      = 1'b0;
                dump_idx_next = '0;
                state_next    = ST_DUMP;
              end
            end
            default: begin
              out_status_next = STATUS_OK;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          // emit the front entry and advance the ring of held entries
          out_load      = 1'b1;
          out_data_next = front_ext[31:0];
          out_last_next = dump_last;
          ctl.op        = CELL_ROTATE;
          dump_idx_next = dump_idx + IDX_W'(1);
          if (dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_len_next = LEN_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dump_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (out_load) begin
      out_data   <= out_data_next;
      out_len    <= out_len_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {1'b0, out_len, out_data};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_d;
    logic [VALUE_BITS-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = cell_q[0];
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[DEPTH-1];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    bdq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .front_data (cell_q[0]),
      .data       (cell_q[i])
    );
  end

  `BDQ_ASSERT(a_count_bound, count <= FULL_COUNT, "entry count exceeds depth")
  `BDQ_ASSERT(a_dump_blocks, (state == ST_DUMP) |-> !s_tready,
              "request taken during dump")
  `BDQ_ASSERT(a_dump_range, (state == ST_DUMP) |-> (CNT_W'(dump_idx) < count),
              "dump index beyond held entries")
  `BDQ_ASSERT_NEXT(a_insert_grows,
                   accept && (kind == KIND_APPEND_REAR || kind == KIND_INSERT_FRONT)
                     && (count != FULL_COUNT),
                   count == $past(count) + CNT_W'(1), "insert did not grow deque")
  `BDQ_ASSERT_NEXT(a_dump_result, (state == ST_DUMP) && out_free,
                   m_tvalid && (m_tuser == STATUS_OK), "dump step gave no result")

endmodule

// ----- hw/rtl/bdq_cell.sv -----
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] left_data,
  input  logic [VALUE_BITS-1:0] right_data,
  input  logic [VALUE_BITS-1:0] front_data,
  output logic [VALUE_BITS-1:0] data
);

  localparam logic [LEN_BITS-1:0] POS = LEN_BITS'(INDEX);

  logic [VALUE_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      CELL_WRITE_AT: begin
        if (ctl.count == POS) begin
          data_next = ctl.value[VALUE_BITS-1:0];
        end
      end
      CELL_SHIFT_IN: begin
        data_next = (POS == '0) ? ctl.value[VALUE_BITS-1:0] : left_data;
      end
      CELL_SHIFT_OUT: begin
        data_next = right_data;
      end
      CELL_ROTATE: begin
        // the rear cell of the held region takes the front entry
        data_next = (ctl.count - LEN_BITS'(1) == POS) ? front_data : right_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
